@@ sv/mctg_pkg.sv @@
// ----------------------------------------------------------------------------
// MIDI clock tick generator package
// Shared types, message codes and parameter defaults for the tick generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mctg_pkg;

    // Parameter defaults
    localparam int unsigned TICKS_PER_BEAT_DEF = 24;
    localparam int unsigned MAX_TICKS_DEF      = 32;

    // Fixed field widths
    localparam int unsigned BEAT_W   = 48;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned IDX_W    = 40;
    localparam int unsigned MSG_W    = 8;
    localparam int unsigned S_DATA_W = 104;

    // Realtime message codes
    localparam logic [MSG_W-1:0] MSG_START = 8'hFA;
    localparam logic [MSG_W-1:0] MSG_STOP  = 8'hFC;
    localparam logic [MSG_W-1:0] MSG_CLOCK = 8'hF8;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_S,
        ST_MUL_E,
        ST_DECIDE,
        ST_STOP,
        ST_REPHASE,
        ST_START,
        ST_TICK,
        ST_CAP
    } state_t;

    // One result item on its way to the output register
    typedef struct packed {
        logic [MSG_W-1:0] message;
        logic             last;
    } msg_t;

endpackage

`default_nettype wire

@@ sv/mctg_out_stage.sv @@
// ----------------------------------------------------------------------------
// MIDI clock tick generator output stage
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mctg_out_stage (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     push,
    input  wire mctg_pkg::msg_t           item,
    output logic                          free,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [mctg_pkg::MSG_W-1:0]    m_tdata,   // [7:0] message
    output logic                          m_tlast    // last
);
    import mctg_pkg::*;

    logic valid_reg;
    logic valid_next;
    msg_t item_reg;

    // Slot is free when empty or being drained this cycle
    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (push) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    // Control flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (push) begin
            item_reg <= item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = item_reg.message;
    assign m_tlast  = item_reg.last;

endmodule

`default_nettype wire

@@ sv/midi_clock_tick_generator.sv @@
// ----------------------------------------------------------------------------
// MIDI clock tick generator
// Turns host block transport info into Start, Stop and Timing Clock bytes.
// ----------------------------------------------------------------------------
// Each input item carries a playing flag and the block's start and end song
// positions in beats (unsigned 32.16). The block answers with Start, Stop and
// Timing Clock bytes, one per cycle while the downstream side takes them,
// with tlast on the final byte of the item; an idle block with transport
// stopped yields nothing. A playing item holds the sequencer while the
// single shared multiplier scales both positions to ticks, the tick counter
// is phased and re-phased, each of its bytes (at most MAX_TICKS + 1) goes
// through the output register, and the tick loop is closed and the cap
// applied. Every byte waits while the downstream side stalls.
// s_tready is high only while the sequencer is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_clock_tick_generator #(
    parameter int unsigned TICKS_PER_BEAT = mctg_pkg::TICKS_PER_BEAT_DEF,
    parameter int unsigned MAX_TICKS      = mctg_pkg::MAX_TICKS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [mctg_pkg::S_DATA_W-1:0] s_tdata, // [0] playing,
                                                     // [48:1] start_beat,
                                                     // [96:49] end_beat
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [mctg_pkg::MSG_W-1:0]       m_tdata,  // [7:0] message
    output logic                             m_tlast   // last
);
    import mctg_pkg::*;

    localparam int unsigned TPB_W = $clog2(TICKS_PER_BEAT + 1);
    localparam int unsigned PW    = BEAT_W + TPB_W;
    localparam int unsigned FW    = PW - FRAC_W;
    localparam int unsigned CW    = ((FW > IDX_W) ? FW : IDX_W) + 1;
    localparam int unsigned CNT_W = $clog2(MAX_TICKS + 1);

    state_t state_reg, state_next;

    logic              playing_reg, playing_next;
    logic [BEAT_W-1:0] start_reg, start_next;
    logic [BEAT_W-1:0] end_reg, end_next;
    logic [FW-1:0]     s_floor_reg, s_floor_next;
    logic              s_frac_reg, s_frac_next;
    logic [FW-1:0]     e_floor_reg, e_floor_next;
    logic              e_frac_reg, e_frac_next;
    logic              was_running_reg, was_running_next;
    logic              start_pend_reg, start_pend_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [BEAT_W-1:0] mul_a;
    logic [PW-1:0]     mul_p;
    logic [IDX_W-1:0]  ceil_s;
    logic [IDX_W-1:0]  ceil_e;
    logic [IDX_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  cnt_inc;
    logic              rephase;
    logic              due;
    logic              due_next;
    logic              cap_hit;

    logic out_push;
    logic out_free;
    msg_t out_item;

    // Shared multiplier: start position first, then end position
    assign mul_a = (state_reg == ST_MUL_S) ? start_reg : end_reg;
    assign mul_p = PW'(mul_a) * PW'(TICKS_PER_BEAT);

    // Round a tick position up to a whole tick, modulo the index range
    assign ceil_s = IDX_W'(s_floor_reg) + IDX_W'(s_frac_reg);
    assign ceil_e = IDX_W'(e_floor_reg) + IDX_W'(e_frac_reg);

    // Counter compares against the whole-tick part of the end position
    assign idx_inc  = idx_reg + IDX_W'(1);
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign rephase  = (CW'(e_floor_reg) + CW'(1)) < CW'(idx_reg);
    assign due      = (CW'(idx_reg) <= CW'(e_floor_reg)) && (cnt_reg < CNT_W'(MAX_TICKS));
    assign due_next = (CW'(idx_inc) <= CW'(e_floor_reg)) && (cnt_inc < CNT_W'(MAX_TICKS));
    assign cap_hit  = (cnt_reg == CNT_W'(MAX_TICKS));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MUL_S;
                end
            end
            ST_MUL_S: state_next = ST_MUL_E;
            ST_MUL_E: state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (playing_reg) begin
                    state_next = ST_REPHASE;
                end else if (was_running_reg) begin
                    state_next = ST_STOP;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_STOP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_REPHASE: state_next = start_pend_reg ? ST_START : ST_TICK;
            ST_START: begin
                if (out_free) begin
                    state_next = ST_TICK;
                end
            end
            ST_TICK: begin
                if (!due) begin
                    state_next = ST_CAP;
                end
            end
            ST_CAP:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and result items
    always_comb begin
        s_tready = 1'b0;
        out_push = 1'b0;
        out_item = '{message: MSG_CLOCK, last: 1'b0};
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_STOP: begin
                out_push = out_free;
                out_item = '{message: MSG_STOP, last: 1'b1};
            end
            ST_START: begin
                out_push = out_free;
                out_item = '{message: MSG_START, last: !due};
            end
            ST_TICK: begin
                out_push = due && out_free;
                out_item = '{message: MSG_CLOCK, last: !due_next};
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        playing_next     = playing_reg;
        start_next       = start_reg;
        end_next         = end_reg;
        s_floor_next     = s_floor_reg;
        s_frac_next      = s_frac_reg;
        e_floor_next     = e_floor_reg;
        e_frac_next      = e_frac_reg;
        was_running_next = was_running_reg;
        start_pend_next  = start_pend_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    playing_next = s_tdata[0];
                    start_next   = s_tdata[BEAT_W:1];
                    end_next     = s_tdata[2*BEAT_W:BEAT_W+1];
                end
            end
            ST_MUL_S: begin
                s_floor_next = mul_p[PW-1:FRAC_W];
                s_frac_next  = |mul_p[FRAC_W-1:0];
            end
            ST_MUL_E: begin
                e_floor_next = mul_p[PW-1:FRAC_W];
                e_frac_next  = |mul_p[FRAC_W-1:0];
            end
            ST_DECIDE: begin
                start_pend_next = 1'b0;
                if (playing_reg && !was_running_reg) begin
                    start_pend_next  = 1'b1;
                    idx_next         = ceil_s;
                    was_running_next = 1'b1;
                end else if (!playing_reg && was_running_reg) begin
                    was_running_next = 1'b0;
                end
            end
            ST_REPHASE: begin
                cnt_next = '0;
                if (rephase) begin
                    idx_next = ceil_s;
                end
            end
            ST_TICK: begin
                if (due && out_free) begin
                    idx_next = idx_inc;
                    cnt_next = cnt_inc;
                end
            end
            ST_CAP: begin
                if (cap_hit) begin
                    idx_next = ceil_e;
                end
            end
            default: begin
                idx_next = idx_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            was_running_reg <= 1'b0;
            start_pend_reg  <= 1'b0;
            idx_reg         <= '0;
            cnt_reg         <= '0;
        end else begin
            state_reg       <= state_next;
            was_running_reg <= was_running_next;
            start_pend_reg  <= start_pend_next;
            idx_reg         <= idx_next;
            cnt_reg         <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        playing_reg <= playing_next;
        start_reg   <= start_next;
        end_reg     <= end_next;
        s_floor_reg <= s_floor_next;
        s_frac_reg  <= s_frac_next;
        e_floor_reg <= e_floor_next;
        e_frac_reg  <= e_frac_next;
    end

    // Output register
    mctg_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (out_push),
        .item     (out_item),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ sv/mctg_checker.sv @@
// ----------------------------------------------------------------------------
// MIDI clock tick generator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mctg_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [mctg_pkg::MSG_W-1:0]    m_tdata,  // [7:0] message
    input wire logic                          m_tlast   // last
);
    import mctg_pkg::*;

    // Output register comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result item valid right after reset");

    // A stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result item changed");

    // Only realtime codes leave the block
    a_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == MSG_START || m_tdata == MSG_STOP || m_tdata == MSG_CLOCK))
        else $error("unexpected message code");

    // Stop always ends the run of its item
    a_stop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata == MSG_STOP |-> m_tlast)
        else $error("stop message without tlast");

    // The sequencer is busy right after taking an item
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

endmodule

bind midi_clock_tick_generator mctg_checker u_mctg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
